### rtl/tsee_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsee_pkg
// Shared constants, codes and control types for the two-stack evaluator.
// ----------------------------------------------------------------------------
package tsee_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DIV_W       = VALUE_WIDTH + FRAC_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

    typedef enum logic [2:0] {
        KIND_OPEN  = 3'd0,
        KIND_CLOSE = 3'd1,
        KIND_OPER  = 3'd2,
        KIND_NEG   = 3'd3,
        KIND_NUM   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_DIV0  = 3'd1,
        ST_UNDER = 3'd2,
        ST_OVER  = 3'd3,
        ST_SAT   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CALC,
        S_MULW,
        S_DIVW,
        S_FIN,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        RES_ADDSUB,
        RES_MUL,
        RES_DIV,
        RES_ZERO
    } res_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     tok_load;
        logic     depth_inc;
        logic     op_push;
        logic     num_push;
        logic     neg_write;
        logic     opnd_load;
        logic     mul_load;
        logic     div_start;
        logic     pop_write;
        res_sel_t res_sel;
        logic     err_set;
        status_t  err_code;
        logic     emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] kind;
        logic       last;
        logic       v_empty;
        logic       v_lt2;
        logic       v_full;
        logic       o_empty;
        logic       o_full;
        logic       d_zero;
        logic       d_full;
        op_t        opr;
        logic       divisor_zero;
        logic       div_done;
        logic       out_free;
    } stat_t;

endpackage
`default_nettype wire

### rtl/tsee_tok_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsee_tok_if
// Token channel: one token of the expression per beat.
// ----------------------------------------------------------------------------
interface tsee_tok_if;
    logic               valid;
    logic               ready;
    logic [2:0]         token_kind;
    logic [1:0]         op;
    logic signed [31:0] number_value;
    logic               last_token;

    modport source (output valid, output token_kind, output op, output number_value,
                    output last_token, input ready);
    modport sink   (input valid, input token_kind, input op, input number_value,
                    input last_token, output ready);
endinterface
`default_nettype wire

### rtl/tsee_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsee_res_if
// Result channel: one evaluated expression value and its status per beat.
// ----------------------------------------------------------------------------
interface tsee_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic [2:0]         status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface
`default_nettype wire

### rtl/tsee_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsee_div
// Restoring unsigned divider, one quotient bit per clock.
// ----------------------------------------------------------------------------
module tsee_div
    import tsee_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [DIV_W-1:0]       dividend,
    input  wire logic [VALUE_WIDTH-1:0] divisor,
    output logic      [DIV_W-1:0]       quotient,
    output logic                        done
);

    logic [DIV_W-1:0]       n_reg, n_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [VALUE_WIDTH:0]   rem_sh;
    logic [VALUE_WIDTH:0]   rem_sub;
    logic                   ge;

    always_comb
    begin
        rem_sh    = {rem_reg, n_reg[DIV_W-1]};
        rem_sub   = rem_sh - {1'b0, d_reg};
        ge        = (rem_sh >= {1'b0, d_reg});
        n_next    = n_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            n_next    = dividend;
            rem_next  = '0;
            d_next    = divisor;
            cnt_next  = DIV_CNT_W'(DIV_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so it fits the value width.
            rem_next = ge ? rem_sub[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
            n_next   = {n_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign quotient = n_reg;
    assign done     = done_reg;

endmodule
`default_nettype wire

### rtl/tsee_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsee_ctrl
// Sequencer that walks each token through the evaluator datapath.
// ----------------------------------------------------------------------------
module tsee_ctrl
    import tsee_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (stat.kind == KIND_CLOSE && !(stat.v_lt2 || stat.o_empty || stat.d_zero))
                    state_next = S_CALC;
                else
                    state_next = S_FIN;
            end
            S_CALC:
            begin
                case (stat.opr)
                    OP_MUL:  state_next = S_MULW;
                    OP_DIV:  state_next = stat.divisor_zero ? S_FIN : S_DIVW;
                    default: state_next = S_FIN;
                endcase
            end
            S_MULW:
                state_next = S_FIN;
            S_DIVW:
            begin
                if (stat.div_done)
                    state_next = S_FIN;
            end
            S_FIN:
                state_next = stat.last ? S_EMIT : S_IDLE;
            S_EMIT:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.tok_load = in_valid;
            end
            S_EXEC:
            begin
                case (stat.kind)
                    KIND_OPEN:
                    begin
                        if (stat.d_full)
                        begin
                            cmd.err_set  = 1'b1;
                            cmd.err_code = ST_OVER;
                        end
                        else
                            cmd.depth_inc = 1'b1;
                    end
                    KIND_CLOSE:
                    begin
                        if (stat.v_lt2 || stat.o_empty || stat.d_zero)
                        begin
                            cmd.err_set  = 1'b1;
                            cmd.err_code = ST_UNDER;
                        end
                        else
                            cmd.opnd_load = 1'b1;
                    end
                    KIND_OPER:
                    begin
                        if (stat.o_full)
                        begin
                            cmd.err_set  = 1'b1;
                            cmd.err_code = ST_OVER;
                        end
                        else
                            cmd.op_push = 1'b1;
                    end
                    KIND_NEG:
                    begin
                        if (stat.v_empty)
                        begin
                            cmd.err_set  = 1'b1;
                            cmd.err_code = ST_UNDER;
                        end
                        else
                            cmd.neg_write = 1'b1;
                    end
                    KIND_NUM:
                    begin
                        if (stat.v_full)
                        begin
                            cmd.err_set  = 1'b1;
                            cmd.err_code = ST_OVER;
                        end
                        else
                            cmd.num_push = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_CALC:
            begin
                case (stat.opr)
                    OP_MUL:
                        cmd.mul_load = 1'b1;
                    OP_DIV:
                    begin
                        if (stat.divisor_zero)
                        begin
                            cmd.err_set   = 1'b1;
                            cmd.err_code  = ST_DIV0;
                            cmd.pop_write = 1'b1;
                            cmd.res_sel   = RES_ZERO;
                        end
                        else
                            cmd.div_start = 1'b1;
                    end
                    default:
                    begin
                        cmd.pop_write = 1'b1;
                        cmd.res_sel   = RES_ADDSUB;
                    end
                endcase
            end
            S_MULW:
            begin
                cmd.pop_write = 1'b1;
                cmd.res_sel   = RES_MUL;
            end
            S_DIVW:
            begin
                cmd.pop_write = stat.div_done;
                cmd.res_sel   = RES_DIV;
            end
            S_FIN:
            begin
            end
            S_EMIT:
                cmd.emit = stat.out_free;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

### rtl/tsee_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsee_dp
// Evaluator datapath: value and operator stacks, arithmetic, result register.
// ----------------------------------------------------------------------------
module tsee_dp
    import tsee_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    tsee_tok_if.sink  tok,
    tsee_res_if.source res,
    input  wire cmd_t cmd,
    output stat_t     stat
);

    localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    // Saturate a sum that carries one guard bit.
    function automatic logic [VALUE_WIDTH:0] sat_sum(input logic [VALUE_WIDTH:0] s);
        logic [VALUE_WIDTH:0] r;
        if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1])
            r = {1'b1, (s[VALUE_WIDTH] ? VMIN : VMAX)};
        else
            r = {1'b0, s[VALUE_WIDTH-1:0]};
        return r;
    endfunction

    // Apply a sign to a wide magnitude and saturate; the top bit is the flag.
    function automatic logic [VALUE_WIDTH:0] sat_mag(input logic neg,
                                                     input logic [DIV_W-1:0] m);
        logic [VALUE_WIDTH:0] r;
        if (!neg)
        begin
            if (|m[DIV_W-1:VALUE_WIDTH-1])
                r = {1'b1, VMAX};
            else
                r = {1'b0, m[VALUE_WIDTH-1:0]};
        end
        else
        begin
            if ((|m[DIV_W-1:VALUE_WIDTH]) || (m[VALUE_WIDTH-1] && (|m[VALUE_WIDTH-2:0])))
                r = {1'b1, VMIN};
            else
                r = {1'b0, -m[VALUE_WIDTH-1:0]};
        end
        return r;
    endfunction

    logic [2:0]              kind_reg;
    logic [1:0]              op_reg;
    logic [VALUE_WIDTH-1:0]  num_reg;
    logic                    last_reg;

    logic [CNT_W-1:0]        vcnt_reg, vcnt_next;
    logic [CNT_W-1:0]        ocnt_reg, ocnt_next;
    logic [CNT_W-1:0]        depth_reg, depth_next;
    status_t                 err_reg, err_next;

    logic [VALUE_WIDTH-1:0]  vmem [STACK_DEPTH];
    logic [1:0]              omem [STACK_DEPTH];
    logic [VALUE_WIDTH-1:0]  rd_a_reg, rd_b_reg;
    logic [1:0]              rd_op_reg;

    logic [VALUE_WIDTH-1:0]  a_reg, b_reg, ma_reg, mb_reg;
    logic                    neg_reg;
    op_t                     opr_reg;
    logic [2*VALUE_WIDTH-1:0] prod_reg;

    logic                    res_valid_reg, res_valid_next;
    logic [VALUE_WIDTH-1:0]  res_value_reg;
    status_t                 res_status_reg;

    logic [PTR_W-1:0]        top_ptr, below_ptr, push_ptr, opush_ptr, otop_ptr;
    logic                    vmem_we;
    logic [PTR_W-1:0]        vmem_wa;
    logic [VALUE_WIDTH-1:0]  vmem_wd;
    logic                    wr_sat;
    logic [VALUE_WIDTH:0]    addsub_r, mul_r, div_r, neg_r;
    logic [VALUE_WIDTH:0]    a_ext, b_ext;
    logic [DIV_W-1:0]        quotient;
    logic                    div_done;
    status_t                 emit_status;
    logic [VALUE_WIDTH-1:0]  emit_value;

    assign top_ptr   = PTR_W'(vcnt_reg - 1'b1);
    assign below_ptr = PTR_W'(vcnt_reg - 2'd2);
    assign push_ptr  = vcnt_reg[PTR_W-1:0];
    assign opush_ptr = ocnt_reg[PTR_W-1:0];
    assign otop_ptr  = PTR_W'(ocnt_reg - 1'b1);

    tsee_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({ma_reg, {FRAC_BITS{1'b0}}}),
        .divisor  (mb_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    always_comb
    begin
        a_ext    = {a_reg[VALUE_WIDTH-1], a_reg};
        b_ext    = {b_reg[VALUE_WIDTH-1], b_reg};
        addsub_r = sat_sum((opr_reg == OP_SUB) ? (a_ext - b_ext) : (a_ext + b_ext));
        mul_r    = sat_mag(neg_reg, prod_reg[FRAC_BITS +: DIV_W]);
        div_r    = sat_mag(neg_reg, quotient);
        neg_r    = sat_sum(-{rd_b_reg[VALUE_WIDTH-1], rd_b_reg});
    end

    // Value stack write port: a push, a negated top, or the result of a close.
    always_comb
    begin
        vmem_we = 1'b0;
        vmem_wa = push_ptr;
        vmem_wd = num_reg;
        wr_sat  = 1'b0;
        if (cmd.num_push)
            vmem_we = 1'b1;
        else if (cmd.neg_write)
        begin
            vmem_we = 1'b1;
            vmem_wa = top_ptr;
            vmem_wd = neg_r[VALUE_WIDTH-1:0];
            wr_sat  = neg_r[VALUE_WIDTH];
        end
        else if (cmd.pop_write)
        begin
            vmem_we = 1'b1;
            vmem_wa = below_ptr;
            case (cmd.res_sel)
                RES_ADDSUB:
                begin
                    vmem_wd = addsub_r[VALUE_WIDTH-1:0];
                    wr_sat  = addsub_r[VALUE_WIDTH];
                end
                RES_MUL:
                begin
                    vmem_wd = mul_r[VALUE_WIDTH-1:0];
                    wr_sat  = mul_r[VALUE_WIDTH];
                end
                RES_DIV:
                begin
                    vmem_wd = div_r[VALUE_WIDTH-1:0];
                    wr_sat  = div_r[VALUE_WIDTH];
                end
                default:
                    vmem_wd = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (vmem_we)
            vmem[vmem_wa] <= vmem_wd;
        if (cmd.op_push)
            omem[opush_ptr] <= op_reg;
        rd_a_reg  <= vmem[below_ptr];
        rd_b_reg  <= vmem[top_ptr];
        rd_op_reg <= omem[otop_ptr];
    end

    always_comb
    begin
        if (vcnt_reg == '0)
        begin
            emit_value  = '0;
            emit_status = (err_reg == ST_OK) ? ST_UNDER : err_reg;
        end
        else
        begin
            emit_value  = rd_b_reg;
            emit_status = err_reg;
        end
    end

    always_comb
    begin
        vcnt_next  = vcnt_reg;
        ocnt_next  = ocnt_reg;
        depth_next = depth_reg;
        err_next   = err_reg;
        if (cmd.emit)
        begin
            vcnt_next  = '0;
            ocnt_next  = '0;
            depth_next = '0;
            err_next   = ST_OK;
        end
        else
        begin
            if (cmd.num_push)
                vcnt_next = vcnt_reg + 1'b1;
            if (cmd.op_push)
                ocnt_next = ocnt_reg + 1'b1;
            if (cmd.depth_inc)
                depth_next = depth_reg + 1'b1;
            if (cmd.pop_write)
            begin
                vcnt_next  = vcnt_reg - 1'b1;
                ocnt_next  = ocnt_reg - 1'b1;
                depth_next = depth_reg - 1'b1;
            end
            // Only the first error of an expression is kept.
            if (err_reg == ST_OK)
            begin
                if (cmd.err_set)
                    err_next = cmd.err_code;
                else if (wr_sat)
                    err_next = ST_SAT;
            end
        end
    end

    assign res_valid_next = cmd.emit | (res_valid_reg & ~res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg      <= '0;
            ocnt_reg      <= '0;
            depth_reg     <= '0;
            err_reg       <= ST_OK;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            vcnt_reg      <= vcnt_next;
            ocnt_reg      <= ocnt_next;
            depth_reg     <= depth_next;
            err_reg       <= err_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tok_load)
        begin
            kind_reg <= tok.token_kind;
            op_reg   <= tok.op;
            num_reg  <= tok.number_value;
            last_reg <= tok.last_token;
        end
        if (cmd.opnd_load)
        begin
            a_reg   <= rd_a_reg;
            b_reg   <= rd_b_reg;
            ma_reg  <= rd_a_reg[VALUE_WIDTH-1] ? -rd_a_reg : rd_a_reg;
            mb_reg  <= rd_b_reg[VALUE_WIDTH-1] ? -rd_b_reg : rd_b_reg;
            neg_reg <= rd_a_reg[VALUE_WIDTH-1] ^ rd_b_reg[VALUE_WIDTH-1];
            opr_reg <= op_t'(rd_op_reg);
        end
        if (cmd.mul_load)
            prod_reg <= ma_reg * mb_reg;
        if (cmd.emit)
        begin
            res_value_reg  <= emit_value;
            res_status_reg <= emit_status;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.result_value = res_value_reg;
    assign res.status       = res_status_reg;

    always_comb
    begin
        stat              = '0;
        stat.kind         = kind_reg;
        stat.last         = last_reg;
        stat.v_empty      = (vcnt_reg == '0);
        stat.v_lt2        = (vcnt_reg < CNT_W'(2));
        stat.v_full       = (vcnt_reg >= CNT_W'(STACK_DEPTH));
        stat.o_empty      = (ocnt_reg == '0);
        stat.o_full       = (ocnt_reg >= CNT_W'(STACK_DEPTH));
        stat.d_zero       = (depth_reg == '0);
        stat.d_full       = (depth_reg >= CNT_W'(STACK_DEPTH));
        stat.opr          = opr_reg;
        stat.divisor_zero = (mb_reg == '0);
        stat.div_done     = div_done;
        stat.out_free     = ~res_valid_reg | res.ready;
    end

endmodule
`default_nettype wire

### rtl/two_stack_expression_evaluator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_stack_expression_evaluator
// Evaluates fully parenthesized Q16.16 expressions fed one token per beat.
// ----------------------------------------------------------------------------
// Tokens are handled one at a time. A close applies the top operator to the
// two top values; multiply goes through a product register, and divide
// through the bit-serial divider that produces one of 48 quotient bits per
// cycle. A token marked last then waits until the output register is free
// and emits the top value with the sticky status, or zero with an underflow
// status when the value stack is empty; the result sits in an output
// register, so the next expression can start while it waits to be taken.
// Overflowing results saturate, and the first error of an expression is kept
// as its status.
module two_stack_expression_evaluator
    import tsee_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    tsee_tok_if.sink   tok,
    tsee_res_if.source res
);

    cmd_t  cmd;
    stat_t stat;

    tsee_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (tok.valid),
        .in_ready (tok.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tsee_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .tok   (tok),
        .res   (res),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule
`default_nettype wire
